@@ hdl/rtcm3fs_pkg.sv @@
// Shared types, constants and the CRC-24Q byte update for the RTCM3 frame sync.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package rtcm3fs_pkg;

  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 11;
  localparam int LEN_W      = 10;
  localparam int CRC_W      = 24;
  localparam int HDR_LEN    = 3;
  localparam int CRC_LEN    = 3;

  // Result queue geometry: a header lock pushes three results at once
  localparam int MAX_PUSH   = 3;
  localparam int PUSH_W     = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;

  localparam logic [BYTE_W-1:0] PREAMBLE_RST    = 8'hD3;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 10'd1023;

  localparam logic [BYTE_W-1:0] LEN_HI_MASK = 8'h03;
  localparam logic [CRC_W-1:0]  CRC24Q_POLY = 24'h864CFB;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              frame_end;
    logic              crc_ok;
    logic [LEN_W-1:0]  msg_length;
    logic              run_last;
  } res_t;

  // One byte of CRC-24Q, MSB first, no reflection
  function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    logic             msb;
    r = crc ^ {b, 16'h0000};
    for (int i = 0; i < BYTE_W; i++) begin
      msb = r[CRC_W-1];
      r   = {r[CRC_W-2:0], 1'b0};
      if (msb) begin
        r = r ^ CRC24Q_POLY;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rtcm3_frame_sync_crc24q.sv @@
// RTCM3 frame synchronizer with CRC-24Q check: top level, framing state and config.
// Depends on rtcm3fs_pkg and rtcm3fs_res_fifo.
// Results of a byte are registered into the result queue before they are presented.
// Throughput: one byte per cycle; a header lock yields three results, which
// drain one per out_ready cycle through the result queue, so input stalls while it holds two or more.
// Reset (rst, synchronous): queue empty, hunting with empty window, preamble 0xD3,
// max payload 1023.
`default_nettype none

module rtcm3_frame_sync_crc24q (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rtcm3fs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rtcm3fs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rtcm3fs_pkg::BYTE_W-1:0]      data_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [rtcm3fs_pkg::BYTE_W-1:0]           frame_byte,
  output logic [rtcm3fs_pkg::IDX_W-1:0]            byte_index,
  output logic                                     frame_end,
  output logic                                     crc_ok,
  output logic [rtcm3fs_pkg::LEN_W-1:0]            msg_length,
  output logic                                     run_last
);
  import rtcm3fs_pkg::*;

  typedef enum logic {HUNT, FRAME} phase_t;

  // Configuration registers
  logic [BYTE_W-1:0] preamble;
  logic [LEN_W-1:0]  max_payload;

  // Framing state
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] win0, win0_next;
  logic [BYTE_W-1:0] win1, win1_next;
  logic [1:0]        fill, fill_next;
  logic [IDX_W-1:0]  frame_count, frame_count_next;
  logic [LEN_W-1:0]  frame_len, frame_len_next;
  logic [CRC_W-1:0]  crc_accum, crc_accum_next;
  logic [CRC_W-1:0]  crc_rcvd, crc_rcvd_next;
  // CRC from zero over the newest hunting byte, and over the newest two
  logic [CRC_W-1:0]  crc_one, crc_one_next;
  logic [CRC_W-1:0]  crc_two, crc_two_next;

  logic                        accept;
  logic                        room;
  logic [PUSH_W-1:0]           push_n;
  res_t [MAX_PUSH-1:0]         push_data;
  res_t                        head;

  logic [BYTE_W-1:0] len_hi;
  logic [LEN_W-1:0]  hdr_len;
  logic [IDX_W-1:0]  data_end;
  logic [IDX_W-1:0]  last_idx;
  logic [CRC_W-1:0]  rcvd_shift;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign accept    = in_valid && in_ready;

  assign len_hi     = win1 & LEN_HI_MASK;
  assign hdr_len    = {len_hi[1:0], data_byte};
  assign data_end   = IDX_W'(HDR_LEN) + {1'b0, frame_len};
  assign last_idx   = data_end + IDX_W'(CRC_LEN - 1);
  assign rcvd_shift = {crc_rcvd[CRC_W-BYTE_W-1:0], data_byte};

  // Per-byte framing: window check while hunting, index and CRC inside a frame
  always_comb begin
    phase_next       = phase;
    win0_next        = win0;
    win1_next        = win1;
    fill_next        = fill;
    frame_count_next = frame_count;
    frame_len_next   = frame_len;
    crc_accum_next   = crc_accum;
    crc_rcvd_next    = crc_rcvd;
    crc_one_next     = crc_one;
    crc_two_next     = crc_two;
    push_n           = '0;
    push_data        = '0;
    if (accept) begin
      case (phase)
        HUNT: begin
          crc_one_next = crc24q_byte('0, data_byte);
          crc_two_next = crc24q_byte(crc_one, data_byte);
          if (fill < 2'd2) begin
            if (fill == 2'd0) begin
              win0_next = data_byte;
            end else begin
              win1_next = data_byte;
            end
            fill_next = fill + 2'd1;
          end else if (win0 == preamble && hdr_len <= max_payload) begin
            // Lock: emit the three header bytes
            push_n                      = PUSH_W'(MAX_PUSH);
            push_data[0].frame_byte     = win0;
            push_data[0].byte_index     = IDX_W'(0);
            push_data[0].msg_length     = hdr_len;
            push_data[1].frame_byte     = win1;
            push_data[1].byte_index     = IDX_W'(1);
            push_data[1].msg_length     = hdr_len;
            push_data[2].frame_byte     = data_byte;
            push_data[2].byte_index     = IDX_W'(2);
            push_data[2].msg_length     = hdr_len;
            push_data[2].run_last       = 1'b1;
            phase_next       = FRAME;
            frame_count_next = IDX_W'(HDR_LEN);
            frame_len_next   = hdr_len;
            crc_accum_next   = crc24q_byte(crc_two, data_byte);
            crc_rcvd_next    = '0;
            fill_next        = 2'd0;
          end else begin
            // Slide the window by one byte
            win0_next = win1;
            win1_next = data_byte;
          end
        end
        FRAME: begin
          push_n                      = PUSH_W'(1);
          push_data[0].frame_byte     = data_byte;
          push_data[0].byte_index     = frame_count;
          push_data[0].msg_length     = frame_len;
          push_data[0].run_last       = 1'b1;
          if (frame_count < data_end) begin
            crc_accum_next   = crc24q_byte(crc_accum, data_byte);
            frame_count_next = frame_count + IDX_W'(1);
          end else begin
            crc_rcvd_next = rcvd_shift;
            if (frame_count >= last_idx) begin
              push_data[0].frame_end = 1'b1;
              push_data[0].crc_ok    = (rcvd_shift == crc_accum);
              phase_next             = HUNT;
              fill_next              = 2'd0;
              frame_count_next       = '0;
            end else begin
              frame_count_next = frame_count + IDX_W'(1);
            end
          end
        end
        default: begin
          phase_next = HUNT;
        end
      endcase
    end
  end

  // Hold framing state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= HUNT;
      win0        <= '0;
      win1        <= '0;
      fill        <= '0;
      frame_count <= '0;
      frame_len   <= '0;
      crc_accum   <= '0;
      crc_rcvd    <= '0;
      crc_one     <= '0;
      crc_two     <= '0;
      preamble    <= PREAMBLE_RST;
      max_payload <= MAX_PAYLOAD_RST;
    end else begin
      phase       <= phase_next;
      win0        <= win0_next;
      win1        <= win1_next;
      fill        <= fill_next;
      frame_count <= frame_count_next;
      frame_len   <= frame_len_next;
      crc_accum   <= crc_accum_next;
      crc_rcvd    <= crc_rcvd_next;
      crc_one     <= crc_one_next;
      crc_two     <= crc_two_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PREAMBLE:    preamble    <= cfg_data[BYTE_W-1:0];
          REG_MAX_PAYLOAD: max_payload <= cfg_data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  rtcm3fs_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (push_data),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign frame_byte     = head.frame_byte;
  assign byte_index     = head.byte_index;
  assign frame_end      = head.frame_end;
  assign crc_ok         = head.crc_ok;
  assign msg_length     = head.msg_length;
  assign run_last       = head.run_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == FRAME) |-> (frame_count >= IDX_W'(HDR_LEN) && frame_count <= last_idx))
    else $error("frame index outside frame");

  a_lock: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == HUNT && push_n != '0) |=>
      (phase == FRAME && frame_count == IDX_W'(HDR_LEN)))
    else $error("header lock did not enter frame");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last)
    else $error("frame end without run_last");

endmodule

`default_nettype wire

@@ hdl/rtcm3fs_res_fifo.sv @@
// Result queue: takes up to three results per cycle, hands out one per cycle while out_ready is high.
// Depends on rtcm3fs_pkg (res_t and queue geometry).
`default_nettype none

module rtcm3fs_res_fifo (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic [rtcm3fs_pkg::PUSH_W-1:0]               push_n,
  input  wire rtcm3fs_pkg::res_t [rtcm3fs_pkg::MAX_PUSH-1:0] push_data,
  output logic                                              room,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output rtcm3fs_pkg::res_t                                 head
);
  import rtcm3fs_pkg::*;

  res_t [FIFO_DEPTH-1:0] q;
  res_t [FIFO_DEPTH-1:0] q_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [CNT_W-1:0]      base;
  logic                  pop;

  assign out_valid = (cnt != '0);
  assign head      = q[0];
  assign pop       = out_valid && out_ready;
  // Accept a new input only when a full header burst still fits
  assign room      = (cnt <= CNT_W'(FIFO_DEPTH - MAX_PUSH));

  // Shift out the head, then append new results behind what remains
  always_comb begin
    q_next = q;
    if (pop) begin
      for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    base = cnt - CNT_W'(pop);
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (PUSH_W'(k) < push_n) begin
        q_next[PTR_W'(base + CNT_W'(k))] = push_data[k];
      end
    end
    cnt_next = base + CNT_W'(push_n);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != '0) |-> (base + CNT_W'(push_n) <= CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(head)))
    else $error("stalled head changed");

endmodule

`default_nettype wire

@@ sim/tb_rtcm3_frame_sync_crc24q.sv @@
// Testbench for rtcm3_frame_sync_crc24q: sends RTCM3 frames, broken headers, noise and
// register writes, and checks every output transaction against a frame tracker class.
// Depends on rtcm3fs_pkg (types, widths, register indexes) and the block's RTL.
module tb_rtcm3_frame_sync_crc24q;
  timeunit 1ns;
  timeprecision 1ps;

  import rtcm3fs_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RST_CYCLES    = 12;
  localparam int IDLE_PCT      = 26;
  localparam int HOLD_CYCLES   = 90;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SHORT_LEN     = 12;
  localparam int LONG_LEN      = 40;

  // Indexes the block does not decode; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  // Tracks hunting/locked state of the deframer and queues the results each byte causes
  class rtcm_frame_tracker;
    byte_t            preamble;
    logic [LEN_W-1:0] max_len;
    bit               locked;
    byte_t            win [2];
    int               fill;
    int               pos;
    int               len;
    logic [CRC_W-1:0] crc_run;
    logic [CRC_W-1:0] crc_rx;
    res_t             due_bytes [$];
    int               errors;

    function new();
      preamble = PREAMBLE_RST;
      max_len  = MAX_PAYLOAD_RST;
      locked   = 1'b0;
      win[0]   = '0;
      win[1]   = '0;
      fill     = 0;
      pos      = 0;
      len      = 0;
      crc_run  = '0;
      crc_rx   = '0;
      errors   = 0;
    endfunction

    // Bit-serial CRC-24Q, data MSB first
    static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc, byte_t b);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        fb = c[CRC_W-1] ^ b[i];
        c  = {c[CRC_W-2:0], 1'b0};
        if (fb) begin
          c = c ^ CRC24Q_POLY;
        end
      end
      return c;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_PREAMBLE) begin
        preamble = val[BYTE_W-1:0];
      end else if (idx == REG_MAX_PAYLOAD) begin
        max_len = val[LEN_W-1:0];
      end
    endfunction

    function void push(byte_t b, int idx, bit fin, bit ok, bit tail);
      res_t r;
      r.frame_byte     = b;
      r.byte_index     = idx[IDX_W-1:0];
      r.frame_end      = fin;
      r.crc_ok         = ok;
      r.msg_length     = len[LEN_W-1:0];
      r.run_last       = tail;
      due_bytes = {due_bytes, r};
    endfunction

    // Advance the framing state by one accepted input byte
    function void stream_byte(byte_t b);
      int hdr_len;
      if (!locked) begin
        if (fill < 2) begin
          win[fill] = b;
          fill++;
          return;
        end
        hdr_len = {(win[1] & LEN_HI_MASK), b};
        if (win[0] == preamble && hdr_len <= max_len) begin
          // lock: emit the three header bytes at once
          len     = hdr_len;
          crc_run = crc_step(crc_step(crc_step('0, win[0]), win[1]), b);
          push(win[0], 0, 1'b0, 1'b0, 1'b0);
          push(win[1], 1, 1'b0, 1'b0, 1'b0);
          push(b, 2, 1'b0, 1'b0, 1'b1);
          locked = 1'b1;
          pos    = HDR_LEN;
          crc_rx = '0;
          fill   = 0;
        end else begin
          // slide the window by one byte
          win[0] = win[1];
          win[1] = b;
        end
      end else if (pos < HDR_LEN + len) begin
        crc_run = crc_step(crc_run, b);
        push(b, pos, 1'b0, 1'b0, 1'b1);
        pos++;
      end else begin
        crc_rx = {crc_rx[CRC_W-BYTE_W-1:0], b};
        if (pos >= HDR_LEN + len + CRC_LEN - 1) begin
          push(b, pos, 1'b1, crc_rx == crc_run, 1'b1);
          locked = 1'b0;
          fill   = 0;
          pos    = 0;
        end else begin
          push(b, pos, 1'b0, 1'b0, 1'b1);
          pos++;
        end
      end
    endfunction

    function void mismatch(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    // Compare one output transaction with the oldest expected result
    function void compare_output(res_t got);
      res_t want;
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected output: expected none, got byte %0h index %0d",
                 $time, got.frame_byte, got.byte_index);
        errors++;
        return;
      end
      want = due_bytes[0];
      due_bytes.delete(0);
      if (got.frame_byte !== want.frame_byte)
        mismatch("frame_byte", want.frame_byte, got.frame_byte);
      if (got.byte_index !== want.byte_index)
        mismatch("byte_index", want.byte_index, got.byte_index);
      if (got.frame_end !== want.frame_end)
        mismatch("frame_end", want.frame_end, got.frame_end);
      if (got.crc_ok !== want.crc_ok)
        mismatch("crc_ok", want.crc_ok, got.crc_ok);
      if (got.msg_length !== want.msg_length)
        mismatch("msg_length", want.msg_length, got.msg_length);
      if (got.run_last !== want.run_last)
        mismatch("run_last", want.run_last, got.run_last);
    endfunction

    function int outstanding();
      return due_bytes.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  byte_t                 data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  byte_t                 frame_byte;
  logic [IDX_W-1:0]      byte_index;
  logic                  frame_end;
  logic                  crc_ok;
  logic [LEN_W-1:0]      msg_length;
  logic                  run_last;
  res_t                  seen;

  rtcm_frame_tracker tracker;
  bit                calm = 1'b0;
  bit                hold_req = 1'b0;
  int                bytes_sent = 0;
  int                cycles = 0;

  rtcm3_frame_sync_crc24q dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_byte     (frame_byte),
    .byte_index     (byte_index),
    .frame_end      (frame_end),
    .crc_ok         (crc_ok),
    .msg_length     (msg_length),
    .run_last       (run_last)
  );

  assign seen = {frame_byte, byte_index, frame_end, crc_ok, msg_length, run_last};

  always #(CLK_HALF) clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** rtcm3_frame_sync_crc24q: FAILED **");
      $finish;
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.compare_output(seen);
    end
  end

  // Drive out_ready: random stalls, none while calm, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one byte, with an optional random gap first; return after its transaction
  task automatic send_byte(input byte_t b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    data_byte = b;
    do @(posedge clk); while (!in_ready);
    tracker.stream_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_t q[$], input int first, input int count);
    for (int i = first; i < first + count; i++) begin
      send_byte(q[i]);
    end
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Append the big-endian CRC-24Q of everything already in q
  function automatic void add_crc(ref byte_t q[$]);
    logic [CRC_W-1:0] crc;
    crc = '0;
    foreach (q[i]) begin
      crc = rtcm_frame_tracker::crc_step(crc, q[i]);
    end
    q = {q, crc[23:16], crc[15:8], crc[7:0]};
  endfunction

  // Build a frame for the current preamble; optionally flip one CRC bit
  function automatic void build_frame(input int plen, input bit corrupt, ref byte_t q[$]);
    byte_t len_hi;
    int    k;
    q.delete();
    len_hi      = byte_t'($urandom);
    len_hi[1:0] = plen[9:8];
    q = {tracker.preamble, len_hi, plen[7:0]};
    for (k = 0; k < plen; k++) begin
      q = {q, byte_t'($urandom)};
    end
    add_crc(q);
    if (corrupt) begin
      k    = q.size() - 1 - $urandom_range(2);
      q[k] = q[k] ^ (byte_t'(1) << $urandom_range(7));
    end
  endfunction

  // Finish any open frame, then leave a window that cannot match the preamble
  task automatic resync();
    byte_t filler;
    filler = ~tracker.preamble;
    do begin
      while (tracker.locked) send_byte(filler);
      repeat (2) send_byte(filler);
    end while (tracker.locked);
  endtask

  // Mostly well-formed frames, some bad CRCs, broken headers and noise
  task automatic random_traffic(input int n);
    byte_t q[$];
    int    stop;
    int    pick;
    int    plen;
    int    top;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      top  = (tracker.max_len < SHORT_LEN) ? tracker.max_len : SHORT_LEN;
      if (pick < 72) begin
        plen = $urandom_range(top, 0);
        build_frame(plen, $urandom_range(9) == 0, q);
        send_bytes(q, 0, q.size());
      end else if (pick < 86) begin
        // header only: over the limit if possible, else a truncated frame
        if (tracker.max_len < MAX_PAYLOAD_RST) begin
          plen = $urandom_range(MAX_PAYLOAD_RST, tracker.max_len + 1);
        end else begin
          plen = $urandom_range(top, 0);
        end
        build_frame(plen, 1'b0, q);
        send_bytes(q, 0, HDR_LEN);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(byte_t'($urandom));
      end
    end
  endtask

  initial begin
    byte_t q[$];
    int    cut;
    tracker = new();
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero payload with good CRC, all-zero header fields
    q = '{PREAMBLE_RST, 8'h00, 8'h00};
    add_crc(q);
    send_bytes(q, 0, q.size());
    // Bad CRC with a preamble inside the payload: consumed whole, no rescan
    q = '{PREAMBLE_RST, 8'hFC, 8'h02, PREAMBLE_RST, 8'hFF};
    add_crc(q);
    q[q.size() - 1] = q[q.size() - 1] ^ 8'h80;
    send_bytes(q, 0, q.size());
    // Noise ahead of a frame: rejected windows slide until the header lines up
    q = '{PREAMBLE_RST, 8'h00, 8'h01, 8'h3C};
    add_crc(q);
    q = {8'h55, 8'hAA, q};
    send_bytes(q, 0, q.size());
    random_traffic(50);

    // Lowest limits; spare indexes are ignored
    settle();
    write_reg(REG_PREAMBLE, 10'h000);
    write_reg(REG_MAX_PAYLOAD, 10'd0);
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
    random_traffic(40);

    // Highest limits; upper data bits of the preamble write are dropped
    settle();
    write_reg(REG_PREAMBLE, 10'h3FF);
    write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
    calm = 1'b1;
    random_traffic(40);
    calm = 1'b0;
    hold_req = 1'b1;
    random_traffic(30);

    // One long frame, well past the random lengths
    resync();
    build_frame(LONG_LEN, 1'b0, q);
    send_bytes(q, 0, q.size());

    // Rewrite registers mid-frame; the open frame keeps its length
    resync();
    build_frame(10, $urandom_range(1), q);
    cut = HDR_LEN + 4;
    send_bytes(q, 0, cut);
    settle();
    write_reg(REG_MAX_PAYLOAD, CFG_DATA_W'($urandom_range(20, 4)));
    write_reg(REG_PREAMBLE, CFG_DATA_W'($urandom_range(255)));
    send_bytes(q, cut, q.size() - cut);
    random_traffic(50);

    settle();
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("** rtcm3_frame_sync_crc24q: PASSED **");
    end else begin
      $display("** rtcm3_frame_sync_crc24q: FAILED **");
    end
    $finish;
  end

endmodule

@@ rtcm3_frame_sync_crc24q.f @@
hdl/rtcm3fs_pkg.sv
hdl/rtcm3fs_res_fifo.sv
hdl/rtcm3_frame_sync_crc24q.sv
sim/tb_rtcm3_frame_sync_crc24q.sv
